### rtl/bdpq_pkg.sv
package bdpq_pkg;

    // default ring depth of the press queue, in slots
    localparam int QUEUE_DEPTH_DEF = 8;

    // number of debounced buttons
    localparam int NUM_BUTTONS = 3;

    // debounce hold-off after reset
    localparam logic [15:0] DEBOUNCE_RST = 16'd50;

    // buttons that are backed by the interrupt hold-off (power and dispense)
    localparam logic [NUM_BUTTONS-1:0] HOLDOFF_MASK = 3'b101;

    // button ids as they appear in the queue
    localparam logic [1:0] BTN_POWER    = 2'd0;
    localparam logic [1:0] BTN_RESET    = 2'd1;
    localparam logic [1:0] BTN_DISPENSE = 2'd2;

    // command codes of one request
    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_IRQ    = 2'd1,
        CMD_POP    = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    // control from the top level into the press queue
    typedef struct packed {
        logic [NUM_BUTTONS-1:0] push_mask;
        logic                   pop;
    } t_queue_req;

    // answer of the press queue to a pop
    typedef struct packed {
        logic       valid;
        logic [1:0] id;
    } t_queue_rsp;

endpackage

### rtl/bdpq_lane.sv
module bdpq_lane
    import bdpq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_level,
    output logic o_press
);

    logic r_prev;
    logic r_stable;
    logic n_prev;
    logic n_stable;
    logic w_change;

    // two agreeing samples that differ from the confirmed level flip it
    always_comb begin
        w_change = i_en && (i_level == r_prev) && (i_level != r_stable);
        n_stable = w_change ? i_level : r_stable;
        n_prev   = i_en ? i_level : r_prev;
        o_press  = w_change && i_level;
    end

    // sample and confirmed level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= 1'b0;
            r_stable <= 1'b0;
        end else begin
            r_prev   <= n_prev;
            r_stable <= n_stable;
        end
    end

endmodule

### rtl/bdpq_press_queue.sv
module bdpq_press_queue
    import bdpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_queue_req i_req,
    output t_queue_rsp o_rsp
);

    localparam int CW = $clog2(QUEUE_DEPTH);
    localparam logic [CW-1:0] LAST_ROW  = CW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] MAX_COUNT = CW'(QUEUE_DEPTH - 1);

    // each row holds the presses of one sample as a button mask
    logic [NUM_BUTTONS-1:0] mem [QUEUE_DEPTH];

    logic [CW-1:0]          r_count;
    logic [CW-1:0]          r_rows;
    logic [CW-1:0]          r_wr_row;
    logic [CW-1:0]          r_rd_row;
    logic [NUM_BUTTONS-1:0] r_front;
    logic [NUM_BUTTONS-1:0] r_rd_data;

    logic [CW-1:0]          n_count;
    logic [CW-1:0]          n_rows;
    logic [CW-1:0]          n_wr_row;
    logic [CW-1:0]          n_rd_row;
    logic [NUM_BUTTONS-1:0] n_front;

    logic [CW-1:0]          w_free;
    logic [1:0]             w_push_cnt;
    logic [NUM_BUTTONS-1:0] w_keep;
    logic                   w_wr_en;
    logic                   w_empty;
    logic [NUM_BUTTONS-1:0] w_cur;
    logic [NUM_BUTTONS-1:0] w_low;
    logic                   w_hit;
    logic [1:0]             w_id;

    // keep presses in button order while free slots remain
    always_comb begin
        w_free     = MAX_COUNT - r_count;
        w_push_cnt = 2'd0;
        w_keep     = '0;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (i_req.push_mask[b] && ((CW+2)'(w_push_cnt) < (CW+2)'(w_free))) begin
                w_keep[b]  = 1'b1;
                w_push_cnt = w_push_cnt + 2'd1;
            end
        end
        w_wr_en = (w_keep != '0);
    end

    // oldest press: leftover of a started row, else the prefetched row
    always_comb begin
        w_empty = (r_front == '0) && (r_rows == '0);
        w_cur   = (r_front != '0) ? r_front : r_rd_data;
        w_hit   = i_req.pop && !w_empty;
        if (w_cur[0]) begin
            w_low = 3'b001;
            w_id  = BTN_POWER;
        end else if (w_cur[1]) begin
            w_low = 3'b010;
            w_id  = BTN_RESET;
        end else begin
            w_low = 3'b100;
            w_id  = BTN_DISPENSE;
        end
        o_rsp.valid = w_hit;
        o_rsp.id    = w_hit ? w_id : BTN_POWER;
    end

    // pointer, row and id count updates
    always_comb begin
        n_front  = r_front;
        n_rd_row = r_rd_row;
        n_wr_row = r_wr_row;
        n_rows   = r_rows;
        n_count  = r_count + CW'(w_push_cnt);
        if (w_wr_en) begin
            n_wr_row = (r_wr_row == LAST_ROW) ? '0 : r_wr_row + 1'b1;
            n_rows   = r_rows + 1'b1;
        end
        if (w_hit) begin
            n_front = w_cur & ~w_low;
            n_count = r_count - 1'b1;
            if (r_front == '0) begin
                n_rd_row = (r_rd_row == LAST_ROW) ? '0 : r_rd_row + 1'b1;
                n_rows   = r_rows - 1'b1;
            end
        end
    end

    // row storage with a prefetch of the next row to be read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[r_wr_row] <= w_keep;
        end
        if (w_wr_en && (r_wr_row == n_rd_row)) begin
            r_rd_data <= w_keep;
        end else begin
            r_rd_data <= mem[n_rd_row];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rows   <= '0;
            r_wr_row <= '0;
            r_rd_row <= '0;
            r_front  <= '0;
        end else begin
            r_count  <= n_count;
            r_rows   <= n_rows;
            r_wr_row <= n_wr_row;
            r_rd_row <= n_rd_row;
            r_front  <= n_front;
        end
    end

endmodule

### rtl/button_debounce_press_queue_top.sv
// an accepted result goes to the output register, or to the skid entry while the output register is held
// throughput: one request per cycle while the skid entry is empty (o_ready high), set by the lane and queue update
// a two-entry output buffer (output register and skid entry) accepts one more request while a result waits to be taken
// reset (synchronous, active low) clears button levels, hold-off and queue pointers,
// and loads the debounce period with 50; queue row storage is not cleared
module button_debounce_press_queue_top
    import bdpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_now_ms,
    input  logic        i_power_pressed,
    input  logic        i_reset_pressed,
    input  logic        i_dispense_pressed,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_pop_valid,
    output logic [1:0]  o_pop_id
);

    logic [15:0]            r_debounce;
    logic [31:0]            r_hold;
    logic [31:0]            n_hold;
    logic                   r_out_v;
    t_queue_rsp             r_out;
    logic                   r_skid_v;
    t_queue_rsp             r_skid;

    logic                   w_acc;
    t_cmd                   w_cmd;
    logic                   w_held;
    logic [31:0]            w_ready_ms;
    logic [NUM_BUTTONS-1:0] w_levels;
    logic [NUM_BUTTONS-1:0] w_en;
    logic [NUM_BUTTONS-1:0] w_press;
    t_queue_req             w_req;
    t_queue_rsp             w_rsp;
    logic                   w_out_take;

    // request decode and hold-off test
    always_comb begin
        w_acc      = i_valid && o_ready;
        w_cmd      = t_cmd'(i_cmd);
        w_held     = (r_hold != 32'd0) && (i_now_ms < r_hold);
        w_ready_ms = i_now_ms + {16'd0, r_debounce};
        w_levels   = {i_dispense_pressed, i_reset_pressed, i_power_pressed};
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            w_en[b] = w_acc && (w_cmd == CMD_SAMPLE) && !(HOLDOFF_MASK[b] && w_held);
        end
        n_hold = r_hold;
        if (w_acc && (w_cmd == CMD_IRQ) && (w_ready_ms > r_hold)) begin
            n_hold = w_ready_ms;
        end
        w_req.push_mask = w_press;
        w_req.pop       = w_acc && (w_cmd == CMD_POP);
    end

    // one debounce lane per button
    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        bdpq_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en[g]),
            .i_level (w_levels[g]),
            .o_press (w_press[g])
        );
    end

    // merge lane presses into the queue in button order
    bdpq_press_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // debounce period and hold-off time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RST;
            r_hold     <= 32'd0;
        end else begin
            if (i_cfg_we) begin
                r_debounce <= i_cfg_wdata;
            end
            r_hold <= n_hold;
        end
    end

    // output register with skid entry
    assign o_ready    = !r_skid_v;
    assign w_out_take = r_out_v && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || w_out_take) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= w_acc;
            end
        end else if (w_acc) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || w_out_take) begin
            r_out <= r_skid_v ? r_skid : w_rsp;
        end else if (w_acc) begin
            r_skid <= w_rsp;
        end
    end

    assign o_valid     = r_out_v;
    assign o_pop_valid = r_out.valid;
    assign o_pop_id    = r_out.id;

endmodule
